// ===== rtl/atfb_pkg.sv =====
// shared constants and types of the transmit frame builder
package atfb_pkg;

  // frame layout
  localparam int unsigned FrameBytes   = 22;
  localparam int unsigned HeldBytes    = FrameBytes - 1;
  localparam int unsigned PosW         = 5;
  localparam int unsigned CsumFirstPos = 3;

  localparam logic [PosW-1:0] LastPos   = PosW'(FrameBytes - 1);
  localparam logic [PosW-1:0] CsumFirst = PosW'(CsumFirstPos);

  localparam logic [7:0]  StartDelim = 8'h7E;
  localparam logic [15:0] FrameLen   = 16'h0012;
  localparam logic [7:0]  CsumBase   = 8'hFF;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEST_ADDR_A = 3'd0,
    CFG_DEST_ADDR_B = 3'd1,
    CFG_FRAME_IDENT = 3'd2,
    CFG_NET_ADDR    = 3'd3,
    CFG_HOP_RADIUS  = 3'd4,
    CFG_TX_OPTIONS  = 3'd5
  } cfg_idx_e;

  // register reset values
  localparam logic [63:0] DestAddrAReset  = 64'h0013_A200_4163_CBB1;
  localparam logic [63:0] DestAddrBReset  = 64'h0013_A200_4163_CBAB;
  localparam logic [7:0]  FrameIdentReset = 8'h01;
  localparam logic [15:0] NetAddrReset    = 16'hFFFE;
  localparam logic [7:0]  HopRadiusReset  = 8'h00;
  localparam logic [7:0]  TxOptionsReset  = 8'h00;

endpackage

// ===== rtl/atfb_msg_if.sv =====
// message request channel of the transmit frame builder
interface atfb_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_type;
  logic       dest_select;
  logic [7:0] msg_ident;
  logic [7:0] payload_0;
  logic [7:0] payload_1;
  logic [7:0] payload_2;

  modport source (
    output valid, frame_type, dest_select, msg_ident, payload_0, payload_1, payload_2,
    input  ready
  );
  modport sink (
    input  valid, frame_type, dest_select, msg_ident, payload_0, payload_1, payload_2,
    output ready
  );
endinterface

// ===== rtl/atfb_byte_if.sv =====
// frame byte channel of the transmit frame builder
interface atfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (
    output valid, frame_byte, frame_end,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, frame_end,
    output ready
  );
endinterface

// ===== rtl/api_transmit_frame_builder_core.sv =====
// transmit-request frame builder: one message in, 22 frame bytes out
//
// Each accepted message request becomes a 22-byte API transmit-request frame sent one
// byte per cycle while the receiver does not stall: start delimiter 0x7E, length 0x0012,
// frame type, frame id, the 8 selected destination address bytes (msb first), network
// address (high byte first), radius, options, identifier, three payload bytes and the
// checksum (frame_end set). The frame is first loaded into a shift register that moves
// a byte at a time; the bytes then move one by one into the output register, and the
// checksum accumulates in the same cycles. A receiver holding off a waiting byte stalls
// the shifting. A new message can be accepted once the checksum byte has entered the
// output register, while it still waits to be taken. Configuration writes are taken at
// any time and apply to the next message.
module api_transmit_frame_builder_core import atfb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  atfb_msg_if.sink            msg_i,
  atfb_byte_if.source         frame_o
);

  localparam int unsigned SregW = 8 * HeldBytes;

  // configuration registers
  logic [63:0] dest_addr_a_q;
  logic [63:0] dest_addr_b_q;
  logic [7:0]  frame_ident_q;
  logic [15:0] net_addr_q;
  logic [7:0]  hop_radius_q;
  logic [7:0]  tx_options_q;

  // frame shift register and sequencing
  logic [SregW-1:0] sreg_q, sreg_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic             busy_q, busy_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_end_q, out_end_d;

  logic        msg_acc;
  logic        emit;
  logic [7:0]  head_byte;
  logic [63:0] sel_addr;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_addr_a_q <= DestAddrAReset;
      dest_addr_b_q <= DestAddrBReset;
      frame_ident_q <= FrameIdentReset;
      net_addr_q    <= NetAddrReset;
      hop_radius_q  <= HopRadiusReset;
      tx_options_q  <= TxOptionsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEST_ADDR_A: dest_addr_a_q <= cfg_data_i;
        CFG_DEST_ADDR_B: dest_addr_b_q <= cfg_data_i;
        CFG_FRAME_IDENT: frame_ident_q <= cfg_data_i[7:0];
        CFG_NET_ADDR:    net_addr_q    <= cfg_data_i[15:0];
        CFG_HOP_RADIUS:  hop_radius_q  <= cfg_data_i[7:0];
        CFG_TX_OPTIONS:  tx_options_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign msg_i.ready = !busy_q;
  assign msg_acc     = msg_i.valid && !busy_q;
  assign emit        = busy_q && (!out_valid_q || frame_o.ready);
  assign head_byte   = sreg_q[SregW-1 -: 8];
  assign sel_addr    = msg_i.dest_select ? dest_addr_b_q : dest_addr_a_q;

  // frame sequencing
  always_comb begin
    sreg_d      = sreg_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;

    // output register drains when taken
    if (out_valid_q && frame_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (msg_acc) begin
      // load the frame body, first byte at the top
      sreg_d = {StartDelim, FrameLen, msg_i.frame_type, frame_ident_q, sel_addr,
                net_addr_q, hop_radius_q, tx_options_q, msg_i.msg_ident,
                msg_i.payload_0, msg_i.payload_1, msg_i.payload_2};
      pos_d  = '0;
      sum_d  = '0;
      busy_d = 1'b1;
    end else if (emit) begin
      out_valid_d = 1'b1;
      if (pos_q == LastPos) begin
        // checksum byte closes the frame
        out_byte_d = CsumBase - sum_q;
        out_end_d  = 1'b1;
        busy_d     = 1'b0;
      end else begin
        out_byte_d = head_byte;
        out_end_d  = 1'b0;
        sreg_d     = {sreg_q[SregW-9:0], 8'h00};
        if (pos_q >= CsumFirst) begin
          sum_d = sum_q + head_byte;
        end
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sreg_q     <= sreg_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.frame_end  = out_end_q;

endmodule
